// ===== sv/spr_pkg.sv =====
// spr_pkg: shared types, constants and the crc byte update for the status packet receiver
// no dependencies; imported by every module of the block
package spr_pkg;

  // header bytes and crc polynomial
  localparam logic [7:0]  HDR_SYNC     = 8'hFF;
  localparam logic [7:0]  HDR_MARK     = 8'hFD;
  localparam logic [7:0]  HDR_RSVD     = 8'h00;
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [16:0] HEAD_BYTES   = 17'd7;
  localparam logic [8:0]  TOTAL_SAT    = 9'd511;

  // byte positions inside the packet and the smallest length value
  localparam logic [8:0]  POS_SYNC0    = 9'd0;
  localparam logic [8:0]  POS_SYNC1    = 9'd1;
  localparam logic [8:0]  POS_MARK     = 9'd2;
  localparam logic [8:0]  POS_RSVD     = 9'd3;
  localparam logic [8:0]  POS_ID       = 9'd4;
  localparam logic [8:0]  POS_LEN_LO   = 9'd5;
  localparam logic [8:0]  POS_LEN_HI   = 9'd6;
  localparam logic [8:0]  POS_INSTR    = 9'd7;
  localparam logic [8:0]  POS_ERROR    = 9'd8;
  localparam logic [15:0] MIN_LENGTH   = 16'd4;

  // configuration register indexes
  localparam logic [7:0]  CFG_MAX_LEN  = 8'd0;
  localparam logic [7:0]  CFG_OPCODE   = 8'd1;

  // reset values of the configuration registers
  localparam logic [8:0]  MAX_LEN_RST  = 9'd128;
  localparam logic [7:0]  OPCODE_RST   = 8'd85;

  // result kinds
  localparam logic        KIND_PARAM   = 1'b0;
  localparam logic        KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    VERD_OK       = 3'd0,
    VERD_BAD_HDR  = 3'd1,
    VERD_TOO_LONG = 3'd2,
    VERD_BAD_LEN  = 3'd3,
    VERD_CRC_ERR  = 3'd4,
    VERD_NOT_STAT = 3'd5
  } verdict_t;

  // one result transaction
  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] source_id;
    logic [7:0] device_error;
    verdict_t   verdict;
    logic [8:0] total_length;
    logic       last;
  } result_t;

  // crc-16, poly 0x8005, msb first, one byte
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // clamp a total length to the 9-bit field
  function automatic logic [8:0] sat_total(input logic [16:0] t);
    return (t > {8'd0, TOTAL_SAT}) ? TOTAL_SAT : t[8:0];
  endfunction

endpackage

// ===== sv/status_packet_receiver.sv =====
// status_packet_receiver: framed status packet parser with crc-16 check
// path: an accepted byte is registered in the parser's input register, and its result in the result buffer
// throughput: one byte per cycle while in_stall is low; the three-entry result buffer limits how far
// the input runs ahead while the output is stalled
// reset: synchronous active-low rst_n clears the packet state and buffer,
// loads max_packet_length 128 and status_opcode 85
module status_packet_receiver import spr_pkg::*; #(
  parameter int PACKET_LIMIT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_item_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_source_id,
  output logic [7:0] out_device_error,
  output logic [2:0] out_verdict,
  output logic [8:0] out_total_length,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic       in_accept;
  logic       busy;
  logic       res_valid;
  result_t    res;
  result_t    head;
  logic [1:0] fifo_cnt;
  logic [8:0] max_len_r;
  logic [7:0] opcode_r;

  // room for the byte in flight and one more
  assign in_stall  = ({1'b0, fifo_cnt} + {2'd0, busy}) >= 3'd3;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      opcode_r  <= OPCODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_LEN) begin
        max_len_r <= cfg_data;
      end
      if (cfg_index == CFG_OPCODE) begin
        opcode_r <= cfg_data[7:0];
      end
    end
  end

  spr_parser #(
    .PACKET_LIMIT(PACKET_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_rx_byte),
    .max_len   (max_len_r),
    .status_op (opcode_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  spr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .count     (fifo_cnt),
    .head      (head)
  );

  // result transaction fields
  assign out_item_kind    = head.item_kind;
  assign out_payload_byte = head.payload_byte;
  assign out_source_id    = head.source_id;
  assign out_device_error = head.device_error;
  assign out_verdict      = head.verdict;
  assign out_total_length = head.total_length;
  assign out_last         = head.last;

endmodule

// ===== sv/spr_parser.sv =====
// spr_parser: input byte register, packet state and the per-byte parse logic
// depends on spr_pkg (types, constants, crc function)
module spr_parser import spr_pkg::*; #(
  parameter int PACKET_LIMIT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [8:0] max_len,
  input  logic [7:0] status_op,
  output logic       busy,
  output logic       res_valid,
  output result_t    res
);

  logic        vld_r;
  logic [7:0]  byte_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [16:0] total_head;
  logic [16:0] total_body;
  logic [16:0] pos_ext;
  logic        restart;

  assign busy       = vld_r;
  assign crc_upd    = crc16_add(crc_r, byte_r);
  assign len_full   = {byte_r, len_r[7:0]};
  assign total_head = HEAD_BYTES + {1'b0, len_full};
  assign total_body = HEAD_BYTES + {1'b0, len_r};
  assign pos_ext    = {8'd0, pos_r} + 17'd2;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
    if (accept) begin
      byte_r <= rx_byte;
    end
  end

  // parse one byte
  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hdr_good_nxt = hdr_good_r;
    len_nxt      = len_r;
    id_nxt       = id_r;
    op_nxt       = op_r;
    err_nxt      = err_r;
    crc_lo_nxt   = crc_lo_r;
    restart      = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    res.source_id    = id_r;
    res.device_error = err_r;
    if (vld_r) begin
      if (pos_r < POS_INSTR) begin
        // head bytes
        crc_nxt = crc_upd;
        pos_nxt = pos_r + 9'd1;
        if ((pos_r == POS_SYNC0 || pos_r == POS_SYNC1) && byte_r != HDR_SYNC) begin
          hdr_good_nxt = 1'b0;
        end
        if (pos_r == POS_MARK && byte_r != HDR_MARK) begin
          hdr_good_nxt = 1'b0;
        end
        if (pos_r == POS_RSVD && byte_r != HDR_RSVD) begin
          hdr_good_nxt = 1'b0;
        end
        if (pos_r == POS_ID) begin
          id_nxt = byte_r;
        end
        if (pos_r == POS_LEN_LO) begin
          len_nxt = {len_r[15:8], byte_r};
        end
        if (pos_r == POS_LEN_HI) begin
          len_nxt = len_full;
          res.item_kind = KIND_VERDICT;
          res.last      = 1'b1;
          // header fault wins, then the length checks
          priority if (!hdr_good_r) begin
            res_valid    = 1'b1;
            res.verdict  = VERD_BAD_HDR;
            restart      = 1'b1;
          end else if (total_head > {8'd0, max_len} ||
                       total_head > 17'(PACKET_LIMIT)) begin
            res_valid        = 1'b1;
            res.verdict      = VERD_TOO_LONG;
            res.total_length = sat_total(total_head);
            restart          = 1'b1;
          end else if (len_full < MIN_LENGTH) begin
            res_valid        = 1'b1;
            res.verdict      = VERD_BAD_LEN;
            res.total_length = sat_total(total_head);
            restart          = 1'b1;
          end else begin
            res_valid = 1'b0;
          end
        end
      end else begin
        res.total_length = sat_total(total_body);
        priority if (pos_ext < total_body) begin
          // instruction, error and parameter bytes
          crc_nxt = crc_upd;
          pos_nxt = pos_r + 9'd1;
          priority if (pos_r == POS_INSTR) begin
            op_nxt = byte_r;
          end else if (pos_r == POS_ERROR) begin
            err_nxt = byte_r;
          end else begin
            res_valid        = 1'b1;
            res.item_kind    = KIND_PARAM;
            res.payload_byte = byte_r;
          end
        end else if (pos_ext == total_body) begin
          // crc low byte
          crc_lo_nxt = byte_r;
          pos_nxt    = pos_r + 9'd1;
        end else begin
          // crc high byte closes the packet
          res_valid     = 1'b1;
          res.item_kind = KIND_VERDICT;
          res.last      = 1'b1;
          priority if ({byte_r, crc_lo_r} != crc_r) begin
            res.verdict = VERD_CRC_ERR;
          end else if (op_r != status_op) begin
            res.verdict = VERD_NOT_STAT;
          end else begin
            res.verdict = VERD_OK;
          end
          restart = 1'b1;
        end
      end
      if (restart) begin
        pos_nxt      = '0;
        crc_nxt      = '0;
        hdr_good_nxt = 1'b1;
        len_nxt      = '0;
        id_nxt       = '0;
        op_nxt       = '0;
        err_nxt      = '0;
        crc_lo_nxt   = '0;
      end
    end
  end

  // packet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= '0;
      hdr_good_r <= 1'b1;
      len_r      <= '0;
      id_r       <= '0;
      op_r       <= '0;
      err_r      <= '0;
      crc_lo_r   <= '0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      hdr_good_r <= hdr_good_nxt;
      len_r      <= len_nxt;
      id_r       <= id_nxt;
      op_r       <= op_nxt;
      err_r      <= err_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

endmodule

// ===== sv/spr_out_fifo.sv =====
// spr_out_fifo: three-entry result buffer that registers results toward the output
// depends on spr_pkg (result_t)
module spr_out_fifo import spr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  input  logic       pop,
  output logic       not_empty,
  output logic [1:0] count,
  output result_t    head
);

  localparam logic [1:0] LAST_IDX = 2'd2;

  result_t    mem_r [3];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign count     = cnt_r;
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== tb/status_packet_receiver_test.sv =====
`timescale 1ns / 100ps
// status_packet_receiver_test: self-checking bench for the status packet receiver
// depends on spr_pkg and status_packet_receiver; a scoreboard class parses the same
// byte stream and queues the results the block must give, in order
module status_packet_receiver_test import spr_pkg::*; ();

  localparam int PACKET_LIMIT = 256;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_BYTES = 1600;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [7:0] CFG_NO_REG = 8'hFF;

  // parser mirror and queue of results still owed by the block
  class packet_scoreboard;
    logic [8:0]  max_len;
    logic [7:0]  status_op;
    int          pos;
    logic [15:0] crc;
    bit          hdr_ok;
    logic [15:0] len_word;
    logic [7:0]  id_byte;
    logic [7:0]  op_byte;
    logic [7:0]  err_byte;
    logic [7:0]  crc_lo;
    result_t     pending_results[$];
    int          errors;

    function new();
      max_len   = MAX_LEN_RST;
      status_op = OPCODE_RST;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      pos      = 0;
      crc      = 16'h0000;
      hdr_ok   = 1'b1;
      len_word = 16'h0000;
      id_byte  = 8'h00;
      op_byte  = 8'h00;
      err_byte = 8'h00;
      crc_lo   = 8'h00;
    endfunction

    function void set_reg(logic [7:0] idx, logic [8:0] val);
      if (idx == CFG_MAX_LEN) max_len = val;
      else if (idx == CFG_OPCODE) status_op = val[7:0];
    endfunction

    // crc-16 over one byte, msb first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
        else r = {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void push(logic kind, logic [7:0] payload, verdict_t v, int total);
      result_t r;
      r.item_kind    = kind;
      r.payload_byte = payload;
      r.source_id    = id_byte;
      r.device_error = err_byte;
      r.verdict      = v;
      r.total_length = (total > 511) ? TOTAL_SAT : 9'(total);
      r.last         = (kind == KIND_VERDICT);
      pending_results.push_back(r);
    endfunction

    // advance the parser by one accepted byte
    function void note_rx_byte(logic [7:0] b);
      int total;
      int limit;
      limit = (max_len < PACKET_LIMIT) ? int'(max_len) : PACKET_LIMIT;
      // head: header, id, length
      if (pos < 7) begin
        crc = crc_step(crc, b);
        case (pos)
          POS_SYNC0, POS_SYNC1: if (b != HDR_SYNC) hdr_ok = 1'b0;
          POS_MARK: if (b != HDR_MARK) hdr_ok = 1'b0;
          POS_RSVD: if (b != HDR_RSVD) hdr_ok = 1'b0;
          POS_ID: id_byte = b;
          POS_LEN_LO: len_word[7:0] = b;
          default: len_word[15:8] = b;
        endcase
        if (pos == POS_LEN_HI) begin
          total = 7 + int'(len_word);
          if (!hdr_ok) begin
            push(KIND_VERDICT, 8'h00, VERD_BAD_HDR, 0);
            restart();
            return;
          end
          if (total > limit) begin
            push(KIND_VERDICT, 8'h00, VERD_TOO_LONG, total);
            restart();
            return;
          end
          if (len_word < MIN_LENGTH) begin
            push(KIND_VERDICT, 8'h00, VERD_BAD_LEN, total);
            restart();
            return;
          end
        end
        pos++;
        return;
      end
      // body: instruction, error, parameters, then crc
      total = 7 + int'(len_word);
      if (pos + 2 < total) begin
        crc = crc_step(crc, b);
        if (pos == POS_INSTR) op_byte = b;
        else if (pos == POS_ERROR) err_byte = b;
        else push(KIND_PARAM, b, VERD_OK, total);
        pos++;
      end else if (pos + 2 == total) begin
        crc_lo = b;
        pos++;
      end else begin
        if ({b, crc_lo} != crc) push(KIND_VERDICT, 8'h00, VERD_CRC_ERR, total);
        else if (op_byte != status_op) push(KIND_VERDICT, 8'h00, VERD_NOT_STAT, total);
        else push(KIND_VERDICT, 8'h00, VERD_OK, total);
        restart();
      end
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result transaction with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d payload %0h verdict %0d",
                 $time, got.item_kind, got.payload_byte, got.verdict);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_check("item_kind", want.item_kind, got.item_kind);
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("source_id", want.source_id, got.source_id);
      field_check("device_error", want.device_error, got.device_error);
      field_check("verdict", want.verdict, got.verdict);
      field_check("total_length", want.total_length, got.total_length);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       out_item_kind;
  logic [7:0] out_payload_byte;
  logic [7:0] out_source_id;
  logic [7:0] out_device_error;
  logic [2:0] out_verdict;
  logic [8:0] out_total_length;
  logic       out_last;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index  = 8'h00;
  logic [8:0] cfg_data   = 9'h000;

  packet_scoreboard sb;
  bit         gaps_on      = 1'b0;
  int         hold_request = 0;
  int         hold_left    = 0;
  int         stall_left   = 0;
  int         sent_bytes   = 0;
  logic [7:0] frame_q[$];

  status_packet_receiver #(.PACKET_LIMIT(PACKET_LIMIT)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_payload_byte (out_payload_byte),
    .out_source_id    (out_source_id),
    .out_device_error (out_device_error),
    .out_verdict      (out_verdict),
    .out_total_length (out_total_length),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check each transaction, then stall at random or for a long hold
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_item_kind, out_payload_byte, out_source_id, out_device_error,
                         out_verdict, out_total_length, out_last});
        stall_left = gaps_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one byte transaction, after a random gap when idling is on
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_byte(b);
    sent_bytes++;
  endtask

  task automatic send_queue();
    while (frame_q.size() > 0) send_byte(frame_q.pop_front());
  endtask

  // feed filler until the parser is back at the start of a packet
  task automatic realign();
    while (sb.pos != 0) send_byte(8'($urandom));
  endtask

  // header, id and length; bad_at names a header byte to corrupt, or -1
  task automatic put_head(input logic [7:0] id, input logic [15:0] len, input int bad_at);
    frame_q.push_back(HDR_SYNC);
    frame_q.push_back(HDR_SYNC);
    frame_q.push_back(HDR_MARK);
    frame_q.push_back(HDR_RSVD);
    if (bad_at >= 0) frame_q[bad_at] = frame_q[bad_at] ^ 8'($urandom_range(1, 255));
    frame_q.push_back(id);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
  endtask

  task automatic send_head(input logic [7:0] id, input logic [15:0] len, input int bad_at);
    realign();
    put_head(id, len, bad_at);
    send_queue();
  endtask

  // full packet; fill < 0 gives random parameters, cut > 0 keeps only that many bytes
  task automatic send_frame(input logic [7:0] id, input int n_params, input logic [7:0] opc,
                            input logic [7:0] err, input bit crc_fault, input int cut,
                            input int fill);
    logic [15:0] c;
    realign();
    put_head(id, 16'(n_params + 4), -1);
    frame_q.push_back(opc);
    frame_q.push_back(err);
    repeat (n_params) frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    c = 16'h0000;
    foreach (frame_q[i]) c = sb.crc_step(c, frame_q[i]);
    if (crc_fault) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    if (cut > 0) while (frame_q.size() > cut) void'(frame_q.pop_back());
    send_queue();
  endtask

  // one packet of a random kind, mostly well formed
  task automatic random_frame();
    int         pick;
    int         limit;
    int         n;
    int         lo;
    logic [7:0] wrong_op;
    limit = (sb.max_len < PACKET_LIMIT) ? int'(sb.max_len) : PACKET_LIMIT;
    n = $urandom_range(0, 12);
    if ($urandom_range(0, 24) == 0 && limit > 11) n = $urandom_range(0, limit - 11);
    wrong_op = 8'($urandom);
    if (wrong_op == sb.status_op) wrong_op = ~wrong_op;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      send_frame(8'($urandom), n, sb.status_op, 8'($urandom), 1'b0, 0, -1);
    end else if (pick < 74) begin
      send_frame(8'($urandom), n, sb.status_op, 8'($urandom), 1'b1, 0, -1);
    end else if (pick < 80) begin
      send_frame(8'($urandom), n, wrong_op, 8'($urandom), $urandom_range(0, 1), 0, -1);
    end else if (pick < 85) begin
      send_head(8'($urandom), 16'($urandom), $urandom_range(0, 3));
    end else if (pick < 89) begin
      lo = (limit > 6) ? limit - 6 : 0;
      send_head(8'($urandom), $urandom_range(0, 1) ? 16'(lo) : 16'($urandom_range(lo, 65535)),
                -1);
    end else if (pick < 93) begin
      send_head(8'($urandom), 16'($urandom_range(0, 3)), -1);
    end else if (pick < 96) begin
      send_frame(8'($urandom), n, sb.status_op, 8'($urandom), 1'b0,
                 $urandom_range(1, n + 10), -1);
    end else begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      send_queue();
    end
  endtask

  task automatic random_burst(input int budget);
    int goal;
    goal = sent_bytes + budget;
    while (sent_bytes < goal) random_frame();
  endtask

  // stop offering and wait until every owed result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] max_len, input logic [7:0] opc);
    settle();
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_OPCODE, {1'b0, opc});
  endtask

  // run limit
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status_packet_receiver test failed");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed packets at reset register values
    send_frame(8'h00, 0, OPCODE_RST, 8'h00, 1'b0, 0, -1);
    send_frame(8'hFF, 2, OPCODE_RST, 8'hFF, 1'b0, 0, 8'hFF);
    send_frame(8'h07, 1, OPCODE_RST, 8'h80, 1'b0, 0, 8'h00);
    send_frame(8'h03, 1, OPCODE_RST, 8'h11, 1'b1, 0, -1);
    send_frame(8'h03, 1, ~OPCODE_RST, 8'h12, 1'b0, 0, -1);
    // crc mismatch takes precedence over a wrong instruction
    send_frame(8'h03, 0, ~OPCODE_RST, 8'h13, 1'b1, 0, -1);
    gaps_on = 1'b1;
    send_head(8'h05, 16'h0003, -1);
    send_head(8'h05, 16'hFFFF, -1);
    // bad header wins over a length that is too long
    send_head(8'h05, 16'hFFFF, 0);
    send_head(8'h05, 16'h0004, 1);
    send_head(8'h05, 16'h0004, 2);
    send_head(8'h05, 16'h0004, 3);
    // packet cut short after its error byte, then recovery
    send_frame(8'h09, 3, OPCODE_RST, 8'h00, 1'b0, 9, -1);
    send_frame(8'h0A, 1, OPCODE_RST, 8'h00, 1'b0, 0, -1);

    // smallest limit, opcode zero: only empty packets fit
    configure(9'd11, 8'h00);
    send_frame(8'h21, 0, 8'h00, 8'h00, 1'b0, 0, -1);
    send_head(8'h21, 16'd5, -1);
    random_burst(150);

    // widest register value clamps to the packet limit; opcode all ones
    configure(9'd511, 8'hFF);
    send_frame(8'h42, 245, 8'hFF, 8'h01, 1'b0, 0, -1);
    send_head(8'h42, 16'd250, -1);
    random_burst(200);

    // long hold at the result side while the sender keeps offering
    configure(9'd256, 8'($urandom));
    gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    send_frame(8'h63, 60, sb.status_op, 8'h00, 1'b0, 0, -1);
    random_burst(200);

    // limit zero rejects every head
    configure(9'd0, 8'($urandom));
    gaps_on = 1'b1;
    random_burst(60);

    // index with no register behind it
    settle();
    write_reg(CFG_NO_REG, 9'($urandom));
    random_burst(100);

    // random settings
    repeat (2) begin
      configure(9'($urandom_range(11, 256)), 8'($urandom));
      gaps_on = $urandom_range(0, 1);
      random_burst(250);
    end

    configure(MAX_LEN_RST, OPCODE_RST);
    gaps_on = 1'b1;
    if (sent_bytes < TARGET_BYTES) random_burst(TARGET_BYTES - sent_bytes);

    settle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status_packet_receiver test passed");
    end else begin
      $display("status_packet_receiver test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spr_pkg.sv
sv/spr_parser.sv
sv/spr_out_fifo.sv
sv/status_packet_receiver.sv
tb/status_packet_receiver_test.sv
